// ===== rtl/sar_pkg.sv =====
// shared types and constants for the stepper acceleration ramp
package sar_pkg;

   // field widths of the request, response and csr ports
   localparam int MOVE_W      = 32;
   localparam int ACCEL_W     = 16;
   localparam int DELAY_OUT_W = 16;
   localparam int PHASE_W     = 2;
   localparam int RSP_W       = 24;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   // divisor 4n+1 with a 16-bit n fits in 18 bits, remainder stays below it
   localparam int DEN_W = ACCEL_W + 2;
   localparam int REM_W = DEN_W;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DELAY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DELAY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_STEPS = 2'd2;

   typedef enum logic [PHASE_W-1:0] {
      PH_STOP  = 2'd0,
      PH_ACCEL = 2'd1,
      PH_RUN   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_START = 2'd1,
      OP_STEP  = 2'd2
   } op_type;

   // controller to datapath
   typedef struct packed {
      op_type op;
      logic   div_load;
      logic   div_step;
      logic   commit;
   } sar_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic accel;
   } sar_status_type;

endpackage

// ===== rtl/sar_ctrl.sv =====
// controller: request sequencing, divide iteration count and response valid
module sar_ctrl #(
   parameter int NUM_W = 35
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_action,
   input  logic                    req_move_nz,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   input  sar_pkg::sar_status_type status,
   output sar_pkg::sar_cmd_type    cmd
);

   localparam int CNT_W = $clog2(NUM_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_APPLY
   } state_type;

   state_type       state_ff, state_in;
   sar_pkg::op_type op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            accept;
   logic            slot_free;
   logic            commit;

   // handshake decode
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign commit    = (state_ff == ST_APPLY) & slot_free;

   // commands to the datapath
   assign cmd.op       = op_ff;
   assign cmd.div_load = accept;
   assign cmd.div_step = (state_ff == ST_DIVIDE);
   assign cmd.commit   = commit;
   assign rsp_valid    = rsp_valid_ff;

   // next state
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_action) begin
                  op_in = req_move_nz ? sar_pkg::OP_START : sar_pkg::OP_NONE;
               end else begin
                  op_in = status.accel ? sar_pkg::OP_STEP : sar_pkg::OP_NONE;
               end
               cnt_in   = CNT_W'(NUM_W - 1);
               state_in = (op_in == sar_pkg::OP_STEP) ? ST_DIVIDE : ST_APPLY;
            end
         end
         ST_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = ST_APPLY;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_APPLY: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= sar_pkg::OP_NONE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/sar_dpath.sv =====
// datapath: csr registers, ramp state, restoring divider and response register
module sar_dpath #(
   parameter int DELAY_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [sar_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sar_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  sar_pkg::sar_cmd_type                cmd,
   output sar_pkg::sar_status_type             status,
   output logic [sar_pkg::RSP_W-1:0]           rsp_data
);

   // numerator 2d + rest needs headroom above the delay width
   localparam int NUM_W = DELAY_BITS + 3;
   localparam int PAD_W = sar_pkg::RSP_W - sar_pkg::DELAY_OUT_W - sar_pkg::PHASE_W;

   logic [sar_pkg::CSR_DATA_W-1:0] first_delay_ff;
   logic [sar_pkg::CSR_DATA_W-1:0] min_delay_ff;
   logic [sar_pkg::ACCEL_W-1:0]    accel_steps_ff;

   sar_pkg::phase_type             phase_ff, phase_in;
   logic [DELAY_BITS-1:0]          delay_ff, delay_in;
   logic [sar_pkg::REM_W-1:0]      rest_ff, rest_in;
   logic [sar_pkg::ACCEL_W-1:0]    idx_ff, idx_in;
   logic [sar_pkg::ACCEL_W-1:0]    steps_ff, steps_in;

   logic [NUM_W-1:0]               div_num_ff, div_num_in;
   logic [sar_pkg::REM_W-1:0]      div_rem_ff, div_rem_in;
   logic [sar_pkg::DEN_W-1:0]      div_den_ff, div_den_in;
   logic [sar_pkg::RSP_W-1:0]      rsp_data_ff;

   logic [sar_pkg::ACCEL_W-1:0]    idx_next;
   logic [sar_pkg::ACCEL_W-1:0]    steps_next;
   logic [sar_pkg::REM_W:0]        partial;
   logic [sar_pkg::REM_W:0]        diff;
   logic                           q_bit;
   logic                           q_over;

   assign status.accel = (phase_ff == sar_pkg::PH_ACCEL);
   assign rsp_data     = rsp_data_ff;
   assign idx_next     = idx_ff + 1'b1;
   assign steps_next   = steps_ff + 1'b1;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         first_delay_ff <= '0;
         min_delay_ff   <= '0;
         accel_steps_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            sar_pkg::CSR_FIRST_DELAY: first_delay_ff <= csr_wdata;
            sar_pkg::CSR_MIN_DELAY:   min_delay_ff   <= csr_wdata;
            sar_pkg::CSR_ACCEL_STEPS: accel_steps_ff <= csr_wdata[sar_pkg::ACCEL_W-1:0];
            default: ;
         endcase
      end
   end

   // one quotient bit per cycle, restoring form
   assign partial = {div_rem_ff, div_num_ff[NUM_W-1]};
   assign diff    = partial - {1'b0, div_den_ff};
   assign q_bit   = (partial >= {1'b0, div_den_ff});

   always_comb begin
      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      div_den_in = div_den_ff;
      if (cmd.div_load) begin
         // numerator 2d + rest, divisor 4(n+1) + 1
         div_num_in = {2'b00, delay_ff, 1'b0} + NUM_W'(rest_ff);
         div_rem_in = '0;
         div_den_in = {idx_next, 2'b01};
      end else if (cmd.div_step) begin
         div_num_in = {div_num_ff[NUM_W-2:0], q_bit};
         div_rem_in = q_bit ? diff[sar_pkg::REM_W-1:0] : partial[sar_pkg::REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
   end

   // ramp state update at commit
   assign q_over = (div_num_ff > NUM_W'(delay_ff));

   always_comb begin
      phase_in = phase_ff;
      delay_in = delay_ff;
      rest_in  = rest_ff;
      idx_in   = idx_ff;
      steps_in = steps_ff;
      case (cmd.op)
         sar_pkg::OP_START: begin
            phase_in = sar_pkg::PH_ACCEL;
            delay_in = first_delay_ff[DELAY_BITS-1:0];
            rest_in  = '0;
            idx_in   = '0;
            steps_in = '0;
         end
         sar_pkg::OP_STEP: begin
            idx_in   = idx_next;
            steps_in = steps_next;
            rest_in  = div_rem_ff;
            delay_in = q_over ? '0 : (delay_ff - div_num_ff[DELAY_BITS-1:0]);
            // ramp length reached: switch to cruise
            if (steps_next >= accel_steps_ff) begin
               delay_in = min_delay_ff[DELAY_BITS-1:0];
               phase_in = sar_pkg::PH_RUN;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sar_pkg::PH_STOP;
         delay_ff <= '0;
         rest_ff  <= '0;
         idx_ff   <= '0;
         steps_ff <= '0;
      end else if (cmd.commit) begin
         phase_ff <= phase_in;
         delay_ff <= delay_in;
         rest_ff  <= rest_in;
         idx_ff   <= idx_in;
         steps_ff <= steps_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= {{PAD_W{1'b0}}, phase_in, delay_in[sar_pkg::DELAY_OUT_W-1:0]};
      end
   end

endmodule

// ===== rtl/stepper_accel_ramp.sv =====
// top level of the stepper linear acceleration ramp step-delay generator
// sequencing: a start or idle-step request goes to the apply state, commits the ramp state and
//   response register once the response slot is free, and rsp_tvalid is registered from that commit;
//   a step while accelerating passes through the divide state first, one quotient bit per cycle
// one request at a time: req_tready is high only in the idle state, reached again at commit
// reset: synchronous, clears csr registers, ramp state (stopped, delay 0) and rsp_tvalid
module stepper_accel_ramp #(
   parameter int DELAY_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sar_pkg::MOVE_W-1:0]         req_tdata,  // [31:0] move_steps
   input  logic                               req_tuser,  // [0] action
   // response
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sar_pkg::RSP_W-1:0]          rsp_tdata,  // [15:0] delay_out, [17:16] phase
   // csr write port
   input  logic                               csr_wen,
   input  logic [sar_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sar_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int NUM_W = DELAY_BITS + 3;

   sar_pkg::sar_cmd_type    cmd;
   sar_pkg::sar_status_type status;

   // sequencing
   sar_ctrl #(
      .NUM_W (NUM_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_action  (req_tuser),
      .req_move_nz (req_tdata != '0),
      .req_ready   (req_tready),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .status      (status),
      .cmd         (cmd)
   );

   // arithmetic and state
   sar_dpath #(
      .DELAY_BITS (DELAY_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_tdata)
   );

endmodule

// ===== rtl/sar_checker.sv =====
// port-level assertions for the stepper acceleration ramp, bound to the top level
module sar_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [sar_pkg::RSP_W-1:0]     rsp_tdata
);

   // no response is pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // one request in flight: ready drops after an accepted request
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous one in progress");

   // phase code three is never reported and padding stays zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[17:16] != 2'd3) && (rsp_tdata[23:18] == 6'd0))
      else $error("bad phase code or padding in response");

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind stepper_accel_ramp sar_checker u_sar_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
